### hw/rtl/stc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the sensor compensation block.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int CfgW      = 48;
    localparam int CfgIdxW   = 3;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;
    localparam int DivSteps  = 64;

    // formula constants
    localparam int TfPressOfs = 128000;
    localparam int PressBase  = 1048576;
    localparam int PressScale = 3125;
    localparam int TfHumOfs   = 76800;
    localparam int HumRound   = 16384;
    localparam int HumBias    = 2097152;
    localparam int HumOne     = 32768;
    localparam int HumRound2  = 8192;
    localparam int HumMax     = 419430400;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TEMP_CALIB    = 3'd0,
        REG_PRESS_CALIB_A = 3'd1,
        REG_PRESS_CALIB_B = 3'd2,
        REG_PRESS_CALIB_C = 3'd3,
        REG_HUM_CALIB_A   = 3'd4,
        REG_HUM_CALIB_B   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [47:0] temp_calib;
        logic [47:0] press_calib_a;
        logic [47:0] press_calib_b;
        logic [47:0] press_calib_c;
        logic [31:0] hum_calib_a;
        logic [39:0] hum_calib_b;
    } calib_t;

    // queue entry between front and back
    typedef struct packed {
        logic [31:0] tf;
        logic [19:0] adc_press;
        logic [15:0] adc_hum;
    } qentry_t;

    // queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // results that ride alongside the divider
    typedef struct packed {
        logic [23:0] tc;
        logic [16:0] hum;
        logic        dz;
    } side_t;

endpackage

### hw/rtl/stc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;

    modport source (output valid, output adc_temp, output adc_press, output adc_hum,
                    input ready);
    modport sink   (input valid, input adc_temp, input adc_press, input adc_hum,
                    output ready);
endinterface

interface stc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic [16:0] humidity_q22_10;
    logic        pressure_divisor_zero;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output humidity_q22_10, output pressure_divisor_zero, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input humidity_q22_10, input pressure_divisor_zero, output ready);
endinterface

### hw/rtl/sensor_thp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_thp_compensation
// Integer compensation of temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// One reading in, one result out, at a sustained rate of one beat per clock
// while the result channel is not stalled. The front computes fine temperature
// in four stages and feeds a four-entry queue; the back runs pressure and
// humidity in nine stages, a 65-stage bit-per-stage divider and four more
// stages, then the output register. The output register holds a result
// under back-pressure while the front keeps taking readings until the queue
// fills. Calibration words are written through cfg_we/cfg_index/cfg_wdata
// and should only change while idle.
module sensor_thp_compensation
(
    input  logic                          clk,
    input  logic                          rst_n,
    stc_in_if.sink                        reading,
    stc_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [stc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [stc_pkg::CfgW-1:0]      cfg_wdata
);
    import stc_pkg::*;

    calib_t  calib_reg;
    qstat_t  qstat;
    qentry_t q_wdata;
    qentry_t q_rdata;
    logic    q_push;
    logic    q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg.temp_calib    <= '0;
            calib_reg.press_calib_a <= 48'd65535;
            calib_reg.press_calib_b <= '0;
            calib_reg.press_calib_c <= '0;
            calib_reg.hum_calib_a   <= '0;
            calib_reg.hum_calib_b   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_CALIB:    calib_reg.temp_calib    <= cfg_wdata;
                REG_PRESS_CALIB_A: calib_reg.press_calib_a <= cfg_wdata;
                REG_PRESS_CALIB_B: calib_reg.press_calib_b <= cfg_wdata;
                REG_PRESS_CALIB_C: calib_reg.press_calib_c <= cfg_wdata;
                REG_HUM_CALIB_A:   calib_reg.hum_calib_a   <= cfg_wdata[31:0];
                REG_HUM_CALIB_B:   calib_reg.hum_calib_b   <= cfg_wdata[39:0];
                default:           ;
            endcase
        end
    end

    stc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (reading),
        .calib   (calib_reg),
        .qstat   (qstat),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    stc_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (qstat)
    );

    stc_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .calib  (calib_reg),
        .qstat  (qstat),
        .q_data (q_rdata),
        .q_pop  (q_pop),
        .result (result)
    );

endmodule

### hw/rtl/stc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_fifo
// Short queue decoupling the temperature front end from the back end.
// ----------------------------------------------------------------------------
module stc_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stc_pkg::qentry_t wdata,
    input  logic             pop,
    output stc_pkg::qentry_t rdata,
    output stc_pkg::qstat_t  stat
);
    import stc_pkg::*;

    qentry_t             mem_reg [FifoDepth];
    logic [FifoAw-1:0]   wp_reg;
    logic [FifoAw-1:0]   rp_reg;
    logic [FifoAw:0]     cnt_reg;
    logic [FifoAw:0]     cnt_next;

    assign stat.full  = (cnt_reg == (FifoAw+1)'(FifoDepth));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/stc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module stc_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     num,
    input  logic [63:0]     den,
    input  stc_pkg::side_t  in_side,
    output logic            out_valid,
    output logic [63:0]     quo,
    output stc_pkg::side_t  out_side
);
    import stc_pkg::*;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] nq;    // numerator bits out at the top, quotient bits in below
        logic [63:0] d;
        logic        neg;
        side_t       side;
    } dstep_t;

    dstep_t              st_reg [0:DivSteps];
    logic [DivSteps:0]   vld_reg;
    dstep_t              entry_next;

    function automatic dstep_t div_step(input dstep_t s);
        logic [64:0] t;
        logic [64:0] diff;
        logic        ge;
        dstep_t      o;
        t    = {s.rem, s.nq[63]};
        diff = t - {1'b0, s.d};
        ge   = (t >= {1'b0, s.d});
        o    = s;
        o.rem = ge ? diff[63:0] : t[63:0];
        o.nq  = {s.nq[62:0], ge};
        return o;
    endfunction

    always_comb
    begin
        entry_next.rem  = '0;
        entry_next.nq   = num[63] ? (64'd0 - num) : num;
        entry_next.d    = den[63] ? (64'd0 - den) : den;
        entry_next.neg  = num[63] ^ den[63];
        entry_next.side = in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DivSteps-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= entry_next;
        end
    end

    for (genvar i = 0; i < DivSteps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i+1] <= div_step(st_reg[i]);
            end
        end
    end

    assign out_valid = vld_reg[DivSteps];
    assign quo       = st_reg[DivSteps].neg ? (64'd0 - st_reg[DivSteps].nq)
                                            : st_reg[DivSteps].nq;
    assign out_side  = st_reg[DivSteps].side;

endmodule

### hw/rtl/stc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_front
// Accepts raw readings and computes the shared fine temperature.
// ----------------------------------------------------------------------------
module stc_front
(
    input  logic              clk,
    input  logic              rst_n,
    stc_in_if.sink            reading,
    input  stc_pkg::calib_t   calib,
    input  stc_pkg::qstat_t   qstat,
    output logic              q_push,
    output stc_pkg::qentry_t  q_data
);
    import stc_pkg::*;

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic               adv;
    logic [3:0]         vld_reg;

    logic signed [31:0] a_reg, b_reg, m1_reg, bb_reg, v1_reg, m2_reg, tf_reg;
    logic signed [31:0] a_next, b_next, m1_next, bb_next, v1_next, m2_next, tf_next;
    logic [19:0]        ap1_reg, ap2_reg, ap3_reg, ap4_reg;
    logic [15:0]        ah1_reg, ah2_reg, ah3_reg, ah4_reg;

    assign t1 = calib.temp_calib[15:0];
    assign t2 = calib.temp_calib[31:16];
    assign t3 = calib.temp_calib[47:32];

    assign adv           = !vld_reg[3] || !qstat.full;
    assign reading.ready = adv;
    assign q_push        = vld_reg[3] && !qstat.full;
    assign q_data        = '{tf: tf_reg, adc_press: ap4_reg, adc_hum: ah4_reg};

    always_comb
    begin
        a_next  = $signed(32'(reading.adc_temp >> 3) - (32'(t1) << 1));
        b_next  = $signed(32'(reading.adc_temp >> 4) - 32'(t1));
        m1_next = a_reg * t2;
        bb_next = b_reg * b_reg;
        v1_next = m1_reg >>> 11;
        m2_next = (bb_reg >>> 12) * t3;
        tf_next = v1_reg + (m2_reg >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], reading.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            ap1_reg <= reading.adc_press;
            ah1_reg <= reading.adc_hum;
            m1_reg  <= m1_next;
            bb_reg  <= bb_next;
            ap2_reg <= ap1_reg;
            ah2_reg <= ah1_reg;
            v1_reg  <= v1_next;
            m2_reg  <= m2_next;
            ap3_reg <= ap2_reg;
            ah3_reg <= ah2_reg;
            tf_reg  <= tf_next;
            ap4_reg <= ap3_reg;
            ah4_reg <= ah3_reg;
        end
    end

endmodule

### hw/rtl/stc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_back
// Pressure and humidity pipelines, divider and the output register.
// ----------------------------------------------------------------------------
module stc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::calib_t   calib,
    input  stc_pkg::qstat_t   qstat,
    input  stc_pkg::qentry_t  q_data,
    output logic              q_pop,
    stc_out_if.source         result
);
    import stc_pkg::*;

    // calibration fields
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3;
    logic signed [15:0] h2, h4, h5;
    logic signed [7:0]  h6;

    assign p1 = calib.press_calib_a[15:0];
    assign p2 = calib.press_calib_a[31:16];
    assign p3 = calib.press_calib_a[47:32];
    assign p4 = calib.press_calib_b[15:0];
    assign p5 = calib.press_calib_b[31:16];
    assign p6 = calib.press_calib_b[47:32];
    assign p7 = calib.press_calib_c[15:0];
    assign p8 = calib.press_calib_c[31:16];
    assign p9 = calib.press_calib_c[47:32];
    assign h1 = calib.hum_calib_a[7:0];
    assign h2 = calib.hum_calib_a[23:8];
    assign h3 = calib.hum_calib_a[31:24];
    assign h4 = calib.hum_calib_b[15:0];
    assign h5 = calib.hum_calib_b[31:16];
    assign h6 = calib.hum_calib_b[39:32];

    logic       adv;
    logic [8:0] bv_reg;
    logic [3:0] cv_reg;
    logic       ovld_reg;

    assign adv   = !ovld_reg || result.ready;
    assign q_pop = adv && !qstat.empty;

    // stage 1
    logic signed [31:0] tf_in, tf5;
    logic signed [33:0] w1_1_reg, w1_1_next;
    logic [20:0]        pp_1_reg, pp_2_reg, pp_3_reg, pp_4_reg, pp_1_next;
    logic signed [31:0] hv_1_reg, hv_1_next;
    logic [15:0]        ah_1_reg;
    logic [23:0]        tc_reg [1:9];
    logic [23:0]        tc_1_next;

    // pressure stages
    logic signed [63:0] sq_2_reg, w1p5_2_reg, w1p2_2_reg;
    logic signed [63:0] sq_2_next, w1p5_2_next, w1p2_2_next;
    logic signed [63:0] w2a_3_reg, sqp3_3_reg, w1p5_3_reg, w1p2_3_reg;
    logic signed [63:0] w2a_3_next, sqp3_3_next;
    logic signed [63:0] w2_4_reg, w1b_4_reg, w2_4_next, w1b_4_next;
    logic [63:0]        w1c_5_reg, num0_5_reg, w1c_5_next, num0_5_next;
    logic [63:0]        den_reg [6:9];
    logic [63:0]        num_reg [6:9];
    logic [63:0]        den_6_next, num_6_next;

    // humidity stages
    logic signed [31:0] vh6_2_reg, vh3_2_reg, h5v_2_reg, la_2_reg;
    logic signed [31:0] vh6_2_next, vh3_2_next, h5v_2_next, la_2_next;
    logic signed [31:0] hr_3_reg, l_3_reg, l_4_reg, l_5_reg, hr_3_next, l_3_next;
    logic signed [31:0] rh2_4_reg, rh2_4_next, r4;
    logic signed [31:0] r2_5_reg, r2_5_next;
    logic signed [31:0] hv2_6_reg, hv2_7_reg, hv2_8_reg, hv2_6_next;
    logic signed [31:0] ss_7_reg, ss_7_next, s7;
    logic signed [31:0] sh_8_reg, sh_8_next;
    logic signed [31:0] hf;
    logic [31:0]        hclamp;
    logic [16:0]        hum_9_reg, hum_9_next;

    always_comb
    begin
        tf_in      = $signed(q_data.tf);
        w1_1_next  = 34'(tf_in) - 34'(TfPressOfs);
        tf5        = tf_in + (tf_in <<< 2) + 32'sd128;
        tc_1_next  = 24'(tf5 >>> 8);
        hv_1_next  = tf_in - 32'(TfHumOfs);
        pp_1_next  = 21'(PressBase) - 21'(q_data.adc_press);

        sq_2_next   = w1_1_reg * w1_1_reg;
        w1p5_2_next = w1_1_reg * p5;
        w1p2_2_next = w1_1_reg * p2;
        vh6_2_next  = hv_1_reg * h6;
        vh3_2_next  = hv_1_reg * $signed({1'b0, h3});
        h5v_2_next  = hv_1_reg * h5;
        la_2_next   = $signed((32'(ah_1_reg) << 14) - (32'(h4) << 20) + 32'(HumRound));

        w2a_3_next  = sq_2_reg * p6;
        sqp3_3_next = sq_2_reg * p3;
        hr_3_next   = (vh6_2_reg >>> 10) * ((vh3_2_reg >>> 11) + 32'(HumOne));
        l_3_next    = (la_2_reg - h5v_2_reg) >>> 15;

        w2_4_next   = w2a_3_reg + (w1p5_3_reg <<< 17) + (64'(p4) <<< 35);
        w1b_4_next  = (sqp3_3_reg >>> 8) + (w1p2_3_reg <<< 12);
        r4          = (hr_3_reg >>> 10) + 32'(HumBias);
        rh2_4_next  = r4 * h2;

        w1c_5_next  = ($unsigned(w1b_4_reg) + (64'd1 << 47)) * {48'd0, p1};
        num0_5_next = ({43'd0, pp_4_reg} << 31) - $unsigned(w2_4_reg);
        r2_5_next   = (rh2_4_reg + 32'(HumRound2)) >>> 14;

        den_6_next  = $unsigned($signed(w1c_5_reg) >>> 33);
        num_6_next  = num0_5_reg * 64'(PressScale);
        hv2_6_next  = l_5_reg * r2_5_reg;

        s7          = hv2_6_reg >>> 15;
        ss_7_next   = s7 * s7;

        sh_8_next   = (ss_7_reg >>> 7) * $signed({1'b0, h1});

        hf = hv2_8_reg - (sh_8_reg >>> 4);
        if (hf[31])
        begin
            hclamp = '0;
        end
        else if ($unsigned(hf) > 32'(HumMax))
        begin
            hclamp = 32'(HumMax);
        end
        else
        begin
            hclamp = $unsigned(hf);
        end
        hum_9_next = 17'(hclamp >> 12);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_1_reg   <= w1_1_next;
            tc_reg[1]  <= tc_1_next;
            hv_1_reg   <= hv_1_next;
            pp_1_reg   <= pp_1_next;
            ah_1_reg   <= q_data.adc_hum;

            sq_2_reg   <= sq_2_next;
            w1p5_2_reg <= w1p5_2_next;
            w1p2_2_reg <= w1p2_2_next;
            vh6_2_reg  <= vh6_2_next;
            vh3_2_reg  <= vh3_2_next;
            h5v_2_reg  <= h5v_2_next;
            la_2_reg   <= la_2_next;
            pp_2_reg   <= pp_1_reg;

            w2a_3_reg  <= w2a_3_next;
            sqp3_3_reg <= sqp3_3_next;
            w1p5_3_reg <= w1p5_2_reg;
            w1p2_3_reg <= w1p2_2_reg;
            hr_3_reg   <= hr_3_next;
            l_3_reg    <= l_3_next;
            pp_3_reg   <= pp_2_reg;

            w2_4_reg   <= w2_4_next;
            w1b_4_reg  <= w1b_4_next;
            rh2_4_reg  <= rh2_4_next;
            l_4_reg    <= l_3_reg;
            pp_4_reg   <= pp_3_reg;

            w1c_5_reg  <= w1c_5_next;
            num0_5_reg <= num0_5_next;
            r2_5_reg   <= r2_5_next;
            l_5_reg    <= l_4_reg;

            den_reg[6] <= den_6_next;
            num_reg[6] <= num_6_next;
            hv2_6_reg  <= hv2_6_next;

            den_reg[7] <= den_reg[6];
            num_reg[7] <= num_reg[6];
            hv2_7_reg  <= hv2_6_reg;
            ss_7_reg   <= ss_7_next;

            den_reg[8] <= den_reg[7];
            num_reg[8] <= num_reg[7];
            hv2_8_reg  <= hv2_7_reg;
            sh_8_reg   <= sh_8_next;

            den_reg[9] <= den_reg[8];
            num_reg[9] <= num_reg[8];
            hum_9_reg  <= hum_9_next;

            for (int i = 2; i <= 9; i++)
            begin
                tc_reg[i] <= tc_reg[i-1];
            end
        end
    end

    // divider
    side_t       div_side_in, div_side_out;
    logic        div_valid;
    logic [63:0] div_quo;

    assign div_side_in = '{tc: tc_reg[9], hum: hum_9_reg, dz: (den_reg[9] == '0)};

    stc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (bv_reg[8]),
        .num       (num_reg[9]),
        .den       (den_reg[9]),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side_out)
    );

    // post-division correction terms
    logic signed [63:0] pq, qs;
    logic signed [63:0] p_c1_reg, p_c2_reg, p_c3_reg;
    logic [63:0]        ql2_c1_reg, ql2_c1_next;
    logic [31:0]        qx_c1_reg, qx_c1_next;
    logic signed [63:0] x2m_c1_reg, x2m_c2_reg, x2m_c3_reg, x2m_c1_next;
    logic [63:0]        qq_c2_reg, qq_c2_next;
    logic signed [63:0] x1m_c3_reg, x1m_c3_next;
    logic signed [63:0] sum_c4_reg, sum_c4_next;
    side_t              side_c_reg [1:4];
    logic signed [63:0] pr_full;
    logic [31:0]        pr_next;

    logic [23:0] tc_o_reg;
    logic [31:0] pr_o_reg;
    logic [16:0] hum_o_reg;
    logic        dz_o_reg;

    always_comb
    begin
        pq          = $signed(div_quo);
        qs          = pq >>> 13;
        ql2_c1_next = 64'(qs[31:0]) * 64'(qs[31:0]);
        qx_c1_next  = qs[63:32] * qs[31:0];
        x2m_c1_next = pq * p8;
        // cross term counted twice, shifted into the upper word
        qq_c2_next  = ql2_c1_reg + {qx_c1_reg[30:0], 33'd0};
        x1m_c3_next = $signed(qq_c2_reg) * p9;
        sum_c4_next = p_c3_reg + (x1m_c3_reg >>> 25) + (x2m_c3_reg >>> 19);
        pr_full     = (sum_c4_reg >>> 8) + (64'(p7) <<< 4);
        pr_next     = side_c_reg[4].dz ? '0 : pr_full[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_c1_reg      <= pq;
            ql2_c1_reg    <= ql2_c1_next;
            qx_c1_reg     <= qx_c1_next;
            x2m_c1_reg    <= x2m_c1_next;
            side_c_reg[1] <= div_side_out;

            p_c2_reg      <= p_c1_reg;
            qq_c2_reg     <= qq_c2_next;
            x2m_c2_reg    <= x2m_c1_reg;
            side_c_reg[2] <= side_c_reg[1];

            p_c3_reg      <= p_c2_reg;
            x1m_c3_reg    <= x1m_c3_next;
            x2m_c3_reg    <= x2m_c2_reg;
            side_c_reg[3] <= side_c_reg[2];

            sum_c4_reg    <= sum_c4_next;
            side_c_reg[4] <= side_c_reg[3];

            tc_o_reg      <= side_c_reg[4].tc;
            pr_o_reg      <= pr_next;
            hum_o_reg     <= side_c_reg[4].hum;
            dz_o_reg      <= side_c_reg[4].dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg   <= '0;
            cv_reg   <= '0;
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg   <= {bv_reg[7:0], !qstat.empty};
            cv_reg   <= {cv_reg[2:0], div_valid};
            ovld_reg <= cv_reg[3];
        end
    end

    assign result.valid                 = ovld_reg;
    assign result.temperature_centi     = tc_o_reg;
    assign result.pressure_q24_8        = pr_o_reg;
    assign result.humidity_q22_10       = hum_o_reg;
    assign result.pressure_divisor_zero = dz_o_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && dz_o_reg |-> pr_o_reg == '0)
        else $error("divisor-zero beat carries nonzero pressure");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg |-> hum_o_reg <= 17'd102400)
        else $error("humidity out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(bv_reg) && $stable(cv_reg))
        else $error("back pipeline moved while stalled");

endmodule
